### hdl/ged_pkg.sv
// ----------------------------------------------------------------------------
// ged_pkg
// Shared types, widths and saturation helper for the determinant engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ged_pkg;

  localparam int ELEM_W = 32;
  localparam int WORK_W = 48;
  localparam int DET_W  = 64;
  localparam int FRAC_W = 16;
  localparam int SIZE_W = 4;
  localparam int SWAP_W = 3;

  localparam logic [DET_W-1:0] WORK_MAX = 64'h0000_7FFF_FFFF_FFFF;
  localparam logic [DET_W-1:0] DET_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [DET_W-1:0] DET_ONE  = 64'h0000_0000_0001_0000;

  localparam logic REG_MATRIX_SIZE = 1'b0;

  // write data select
  localparam logic [2:0] WR_ELEM = 3'd0;
  localparam logic [2:0] WR_ZERO = 3'd1;
  localparam logic [2:0] WR_RDA  = 3'd2;
  localparam logic [2:0] WR_RDB  = 3'd3;
  localparam logic [2:0] WR_DIFF = 3'd4;

  typedef struct packed {
    logic       rd_en;
    logic       wr_en;
    logic [2:0] wr_sel;
    logic       div_start;
    logic       mul_start;
    logic       mul_det;
    logic       clear;
    logic       swap_inc;
    logic       det_take;
    logic       det_zero;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic rd_a_zero;
    logic div_done;
    logic mul_done;
    logic out_full;
  } stat_t;

  typedef struct packed {
    logic [DET_W-1:0] value;
    logic             sat;
  } sat_val_t;

  // signed value from sign and magnitude, clamped to [-(maxpos+1), maxpos]
  function automatic sat_val_t sat_signed(input logic neg, input logic [DET_W-1:0] mag,
                                          input logic [DET_W-1:0] maxpos);
    sat_val_t         res;
    logic [DET_W-1:0] m;
    m       = mag;
    res.sat = 1'b0;
    if (neg) begin
      if (mag > maxpos + 64'd1) begin
        m       = maxpos + 64'd1;
        res.sat = 1'b1;
      end
      res.value = -m;
    end else begin
      if (mag > maxpos) begin
        m       = maxpos;
        res.sat = 1'b1;
      end
      res.value = m;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

### hdl/ged_ram.sv
// ----------------------------------------------------------------------------
// ged_ram
// Generic RAM, one write port and two registered read ports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ged_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  wire                     clk,
  input  wire                     we,
  input  wire [$clog2(DEPTH)-1:0] waddr,
  input  wire [WIDTH-1:0]         wdata,
  input  wire                     re,
  input  wire [$clog2(DEPTH)-1:0] raddr_a,
  input  wire [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]        rdata_a,
  output logic [WIDTH-1:0]        rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

`default_nettype wire

### hdl/ged_div.sv
// ----------------------------------------------------------------------------
// ged_div
// Restoring divider, one quotient bit per cycle, Q32.16 ratio with clamp.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ged_div (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                start,
  input  wire signed [ged_pkg::WORK_W-1:0]   num,
  input  wire signed [ged_pkg::WORK_W-1:0]   den,
  output logic                               done,
  output logic signed [ged_pkg::WORK_W-1:0]  result,
  output logic                               sat
);

  logic                         busy;
  logic                         fin;
  logic [5:0]                   cnt;
  logic                         neg;
  logic [ged_pkg::DET_W-1:0]    quo;
  logic [ged_pkg::WORK_W-1:0]   rem;
  logic [ged_pkg::WORK_W-1:0]   dv;
  logic [ged_pkg::WORK_W:0]     trial;
  logic [ged_pkg::WORK_W-1:0]   num_mag;
  logic [ged_pkg::WORK_W-1:0]   den_mag;
  ged_pkg::sat_val_t            clamp;

  assign num_mag = num[ged_pkg::WORK_W-1] ? -num : num;
  assign den_mag = den[ged_pkg::WORK_W-1] ? -den : den;
  assign trial   = {rem, quo[ged_pkg::DET_W-1]};
  assign clamp   = ged_pkg::sat_signed(neg, quo, ged_pkg::WORK_MAX);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '1;
        quo  <= {num_mag, {ged_pkg::FRAC_W{1'b0}}};
        rem  <= '0;
        dv   <= den_mag;
        neg  <= num[ged_pkg::WORK_W-1] ^ den[ged_pkg::WORK_W-1];
      end else if (busy) begin
        if (trial >= {1'b0, dv}) begin
          rem <= ged_pkg::WORK_W'(trial - {1'b0, dv});
          quo <= {quo[ged_pkg::DET_W-2:0], 1'b1};
        end else begin
          rem <= trial[ged_pkg::WORK_W-1:0];
          quo <= {quo[ged_pkg::DET_W-2:0], 1'b0};
        end
        if (cnt == '0) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end else begin
          cnt <= cnt - 6'd1;
        end
      end else if (fin) begin
        fin    <= 1'b0;
        done   <= 1'b1;
        result <= clamp.value[ged_pkg::WORK_W-1:0];
        sat    <= clamp.sat;
      end
    end
  end

endmodule

`default_nettype wire

### hdl/ged_mul.sv
// ----------------------------------------------------------------------------
// ged_mul
// Sequential fixed-point multiplier, four 32x32 partial products, with clamp.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ged_mul (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               start,
  input  wire                               det_mode,
  input  wire signed [ged_pkg::DET_W-1:0]   a,
  input  wire signed [ged_pkg::WORK_W-1:0]  b,
  output logic                              done,
  output logic signed [ged_pkg::DET_W-1:0]  result,
  output logic                              sat
);

  localparam int ACC_W = ged_pkg::DET_W + ged_pkg::WORK_W;

  logic                         busy;
  logic [2:0]                   step;
  logic                         neg;
  logic                         mode;
  logic [ged_pkg::DET_W-1:0]    ma;
  logic [ged_pkg::WORK_W-1:0]   mb;
  logic [63:0]                  pp;
  logic [1:0]                   sh;
  logic [ACC_W-1:0]             acc;
  logic [ACC_W-1:0]             pp_ext;
  logic [31:0]                  a_part;
  logic [31:0]                  b_part;
  logic [ged_pkg::DET_W-1:0]    mag;
  ged_pkg::sat_val_t            clamp;

  assign a_part = step[1] ? ma[63:32] : ma[31:0];
  assign b_part = step[0] ? {16'd0, mb[47:32]} : mb[31:0];

  always_comb begin
    case (sh)
      2'd0:    pp_ext = {48'd0, pp};
      2'd1:    pp_ext = {16'd0, pp, 32'd0};
      default: pp_ext = {pp[47:0], 64'd0};
    endcase
  end

  always_comb begin
    if (|acc[ACC_W-1:80]) begin
      mag = 64'h8000_0000_0000_0000;
    end else begin
      mag = acc[79:16];
    end
    clamp = ged_pkg::sat_signed(neg, mag, mode ? ged_pkg::DET_MAX : ged_pkg::WORK_MAX);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= 3'd0;
        acc  <= '0;
        mode <= det_mode;
        neg  <= a[ged_pkg::DET_W-1] ^ b[ged_pkg::WORK_W-1];
        ma   <= a[ged_pkg::DET_W-1] ? -a : a;
        mb   <= b[ged_pkg::WORK_W-1] ? -b : b;
      end else if (busy) begin
        step <= step + 3'd1;
        if (step <= 3'd3) begin
          pp <= a_part * b_part;
          sh <= {1'b0, step[1]} + {1'b0, step[0]};
        end
        if (step >= 3'd1 && step <= 3'd4) begin
          acc <= acc + pp_ext;
        end
        if (step == 3'd5) begin
          busy   <= 1'b0;
          done   <= 1'b1;
          result <= clamp.value;
          sat    <= clamp.sat;
        end
      end
    end
  end

endmodule

`default_nettype wire

### hdl/ged_datapath.sv
// ----------------------------------------------------------------------------
// ged_datapath
// Matrix RAM, divider, multiplier, determinant and result registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ged_datapath #(
  parameter int MAX_DIM = 8
) (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire ged_pkg::cmd_t                    cmd,
  output ged_pkg::stat_t                        stat,
  input  wire [2*$clog2(MAX_DIM)-1:0]           rd_addr_a,
  input  wire [2*$clog2(MAX_DIM)-1:0]           rd_addr_b,
  input  wire [2*$clog2(MAX_DIM)-1:0]           wr_addr,
  input  wire signed [ged_pkg::ELEM_W-1:0]      element,
  output logic signed [ged_pkg::DET_W-1:0]      det_value,
  output logic [ged_pkg::SWAP_W-1:0]            row_swaps,
  output logic                                  singular,
  output logic                                  overflow,
  output logic                                  result_valid,
  input  wire                                   result_ready
);

  localparam int AW    = 2 * $clog2(MAX_DIM);
  localparam int DEPTH = 1 << AW;

  logic signed [ged_pkg::WORK_W-1:0] rdata_a;
  logic signed [ged_pkg::WORK_W-1:0] rdata_b;
  logic signed [ged_pkg::WORK_W-1:0] wdata;
  logic signed [ged_pkg::WORK_W-1:0] f;
  logic signed [ged_pkg::DET_W-1:0]  det;
  logic [ged_pkg::SWAP_W-1:0]        swaps;
  logic                              sat_hit;
  logic                              sing;

  logic                              div_done;
  logic signed [ged_pkg::WORK_W-1:0] div_res;
  logic                              div_sat;
  logic                              mul_done;
  logic signed [ged_pkg::DET_W-1:0]  mul_res;
  logic                              mul_sat;
  logic signed [ged_pkg::DET_W-1:0]  mul_a;
  logic signed [ged_pkg::WORK_W-1:0] mul_b;

  logic signed [ged_pkg::WORK_W:0]   diff;
  logic signed [ged_pkg::WORK_W-1:0] diff_sat;
  logic                              diff_ovf;
  logic [ged_pkg::DET_W-1:0]         det_mag;
  logic                              det_pos;
  ged_pkg::sat_val_t                 neg_det;

  ged_ram #(
    .WIDTH(ged_pkg::WORK_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk    (clk),
    .we     (cmd.wr_en),
    .waddr  (wr_addr),
    .wdata  (wdata),
    .re     (cmd.rd_en),
    .raddr_a(rd_addr_a),
    .raddr_b(rd_addr_b),
    .rdata_a(rdata_a),
    .rdata_b(rdata_b)
  );

  ged_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (rdata_a),
    .den   (rdata_b),
    .done  (div_done),
    .result(div_res),
    .sat   (div_sat)
  );

  assign mul_a = cmd.mul_det ? det : {{16{rdata_b[ged_pkg::WORK_W-1]}}, rdata_b};
  assign mul_b = cmd.mul_det ? rdata_a : f;

  ged_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd.mul_start),
    .det_mode(cmd.mul_det),
    .a       (mul_a),
    .b       (mul_b),
    .done    (mul_done),
    .result  (mul_res),
    .sat     (mul_sat)
  );

  // saturating subtract of the scaled pivot row
  always_comb begin
    diff     = {rdata_a[ged_pkg::WORK_W-1], rdata_a}
             - {mul_res[ged_pkg::WORK_W-1], mul_res[ged_pkg::WORK_W-1:0]};
    diff_ovf = diff[ged_pkg::WORK_W] ^ diff[ged_pkg::WORK_W-1];
    if (diff_ovf) begin
      diff_sat = diff[ged_pkg::WORK_W] ? {1'b1, {(ged_pkg::WORK_W-1){1'b0}}}
                                       : {1'b0, {(ged_pkg::WORK_W-1){1'b1}}};
    end else begin
      diff_sat = diff[ged_pkg::WORK_W-1:0];
    end
  end

  always_comb begin
    case (cmd.wr_sel)
      ged_pkg::WR_ELEM: wdata = {{16{element[ged_pkg::ELEM_W-1]}}, element};
      ged_pkg::WR_RDA:  wdata = rdata_a;
      ged_pkg::WR_RDB:  wdata = rdata_b;
      ged_pkg::WR_DIFF: wdata = diff_sat;
      default:          wdata = '0;
    endcase
  end

  assign det_pos = !det[ged_pkg::DET_W-1] && (det != '0);
  assign det_mag = det[ged_pkg::DET_W-1] ? -det : det;
  assign neg_det = ged_pkg::sat_signed(det_pos, det_mag, ged_pkg::DET_MAX);

  always_ff @(posedge clk) begin
    if (div_done) begin
      f <= div_res;
    end
    if (cmd.clear) begin
      det <= ged_pkg::DET_ONE;
    end else if (cmd.det_zero) begin
      det <= '0;
    end else if (cmd.det_take) begin
      det <= mul_res;
    end
    if (cmd.out_load) begin
      det_value <= swaps[0] ? neg_det.value : det;
      row_swaps <= swaps;
      singular  <= sing;
      overflow  <= sat_hit | (swaps[0] & neg_det.sat);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      swaps        <= '0;
      sat_hit      <= 1'b0;
      sing         <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (cmd.clear) begin
        swaps   <= '0;
        sat_hit <= 1'b0;
        sing    <= 1'b0;
      end else begin
        if (cmd.swap_inc) begin
          swaps <= swaps + 3'd1;
        end
        if ((div_done && div_sat) || (mul_done && mul_sat)
            || (cmd.wr_en && cmd.wr_sel == ged_pkg::WR_DIFF && diff_ovf)) begin
          sat_hit <= 1'b1;
        end
        if (cmd.det_zero) begin
          sing <= 1'b1;
        end
      end
      if (cmd.out_load) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  assign stat.rd_a_zero = (rdata_a == '0);
  assign stat.div_done  = div_done;
  assign stat.mul_done  = mul_done;
  assign stat.out_full  = result_valid;

endmodule

`default_nettype wire

### hdl/ged_ctrl.sv
// ----------------------------------------------------------------------------
// ged_ctrl
// Sequencer for loading, pivot search, row swap, elimination and product.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ged_ctrl #(
  parameter int MAX_DIM = 8
) (
  input  wire                               clk,
  input  wire                               rst,
  input  wire [ged_pkg::SIZE_W-1:0]         matrix_size,
  input  wire                               cfg_wr,
  input  wire                               element_valid,
  output logic                              element_ready,
  input  wire ged_pkg::stat_t               stat,
  output ged_pkg::cmd_t                     cmd,
  output logic [2*$clog2(MAX_DIM)-1:0]      rd_addr_a,
  output logic [2*$clog2(MAX_DIM)-1:0]      rd_addr_b,
  output logic [2*$clog2(MAX_DIM)-1:0]      wr_addr
);

  localparam int IDX_W = $clog2(MAX_DIM);
  localparam int CNT_W = $clog2(MAX_DIM + 1);
  localparam int AW    = 2 * IDX_W;

  localparam logic [4:0] S_LOAD     = 5'd0;
  localparam logic [4:0] S_COL      = 5'd1;
  localparam logic [4:0] S_SRCH_RD  = 5'd2;
  localparam logic [4:0] S_SRCH_CHK = 5'd3;
  localparam logic [4:0] S_SWP_RD   = 5'd4;
  localparam logic [4:0] S_SWP_W1   = 5'd5;
  localparam logic [4:0] S_SWP_W2   = 5'd6;
  localparam logic [4:0] S_ROW      = 5'd7;
  localparam logic [4:0] S_DIV_GO   = 5'd8;
  localparam logic [4:0] S_DIV_WAIT = 5'd9;
  localparam logic [4:0] S_ELIM_COL = 5'd10;
  localparam logic [4:0] S_MUL_GO   = 5'd11;
  localparam logic [4:0] S_MUL_WAIT = 5'd12;
  localparam logic [4:0] S_ZROW     = 5'd13;
  localparam logic [4:0] S_DET_RD   = 5'd14;
  localparam logic [4:0] S_DET_CHK  = 5'd15;
  localparam logic [4:0] S_DET_WAIT = 5'd16;
  localparam logic [4:0] S_FINAL    = 5'd17;

  logic [4:0]       state, state_next;
  logic [CNT_W-1:0] i, i_next;
  logic [CNT_W-1:0] j, j_next;
  logic [CNT_W-1:0] r, r_next;
  logic [CNT_W-1:0] m, m_next;
  logic [CNT_W-1:0] p, p_next;
  logic [CNT_W-1:0] n;
  logic [CNT_W-1:0] n_last;

  function automatic logic [AW-1:0] addr(input logic [CNT_W-1:0] row,
                                         input logic [CNT_W-1:0] col);
    return {row[IDX_W-1:0], col[IDX_W-1:0]};
  endfunction

  always_comb begin
    if (matrix_size == '0) begin
      n = CNT_W'(1);
    end else if (int'(matrix_size) > MAX_DIM) begin
      n = CNT_W'(MAX_DIM);
    end else begin
      n = CNT_W'(matrix_size);
    end
    n_last = n - CNT_W'(1);
  end

  always_comb begin
    state_next    = state;
    i_next        = i;
    j_next        = j;
    r_next        = r;
    m_next        = m;
    p_next        = p;
    cmd           = '0;
    rd_addr_a     = '0;
    rd_addr_b     = '0;
    wr_addr       = '0;
    element_ready = 1'b0;
    unique case (state)
      S_LOAD: begin
        element_ready = !cfg_wr;
        wr_addr       = addr(i, j);
        if (cfg_wr) begin
          i_next = '0;
          j_next = '0;
        end else if (element_valid) begin
          cmd.wr_en  = 1'b1;
          cmd.wr_sel = ged_pkg::WR_ELEM;
          if (j == n_last) begin
            j_next = '0;
            if (i == n_last) begin
              i_next     = '0;
              r_next     = '0;
              m_next     = '0;
              cmd.clear  = 1'b1;
              state_next = S_COL;
            end else begin
              i_next = i + CNT_W'(1);
            end
          end else begin
            j_next = j + CNT_W'(1);
          end
        end
      end
      S_COL: begin
        if (m == n || r == n) begin
          i_next     = r;
          j_next     = '0;
          state_next = S_ZROW;
        end else begin
          p_next     = r;
          state_next = S_SRCH_RD;
        end
      end
      S_SRCH_RD: begin
        cmd.rd_en  = 1'b1;
        rd_addr_a  = addr(p, m);
        state_next = S_SRCH_CHK;
      end
      S_SRCH_CHK: begin
        if (!stat.rd_a_zero) begin
          if (p != r) begin
            j_next     = '0;
            state_next = S_SWP_RD;
          end else begin
            i_next     = r + CNT_W'(1);
            state_next = S_ROW;
          end
        end else if (p == n_last) begin
          m_next     = m + CNT_W'(1);
          state_next = S_COL;
        end else begin
          p_next     = p + CNT_W'(1);
          state_next = S_SRCH_RD;
        end
      end
      S_SWP_RD: begin
        cmd.rd_en  = 1'b1;
        rd_addr_a  = addr(p, j);
        rd_addr_b  = addr(r, j);
        state_next = S_SWP_W1;
      end
      S_SWP_W1: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = ged_pkg::WR_RDA;
        wr_addr    = addr(r, j);
        state_next = S_SWP_W2;
      end
      S_SWP_W2: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = ged_pkg::WR_RDB;
        wr_addr    = addr(p, j);
        if (j == n_last) begin
          cmd.swap_inc = 1'b1;
          i_next       = r + CNT_W'(1);
          state_next   = S_ROW;
        end else begin
          j_next     = j + CNT_W'(1);
          state_next = S_SWP_RD;
        end
      end
      S_ROW: begin
        if (i == n) begin
          r_next     = r + CNT_W'(1);
          m_next     = m + CNT_W'(1);
          state_next = S_COL;
        end else begin
          cmd.rd_en  = 1'b1;
          rd_addr_a  = addr(i, m);
          rd_addr_b  = addr(r, m);
          state_next = S_DIV_GO;
        end
      end
      S_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (stat.div_done) begin
          j_next     = '0;
          state_next = S_ELIM_COL;
        end
      end
      S_ELIM_COL: begin
        if (j == n) begin
          i_next     = i + CNT_W'(1);
          state_next = S_ROW;
        end else if (j == m) begin
          cmd.wr_en  = 1'b1;
          cmd.wr_sel = ged_pkg::WR_ZERO;
          wr_addr    = addr(i, j);
          j_next     = j + CNT_W'(1);
        end else begin
          cmd.rd_en  = 1'b1;
          rd_addr_a  = addr(i, j);
          rd_addr_b  = addr(r, j);
          state_next = S_MUL_GO;
        end
      end
      S_MUL_GO: begin
        cmd.mul_start = 1'b1;
        state_next    = S_MUL_WAIT;
      end
      S_MUL_WAIT: begin
        if (stat.mul_done) begin
          cmd.wr_en  = 1'b1;
          cmd.wr_sel = ged_pkg::WR_DIFF;
          wr_addr    = addr(i, j);
          j_next     = j + CNT_W'(1);
          state_next = S_ELIM_COL;
        end
      end
      S_ZROW: begin
        if (i == n) begin
          i_next     = '0;
          state_next = S_DET_RD;
        end else begin
          cmd.wr_en  = 1'b1;
          cmd.wr_sel = ged_pkg::WR_ZERO;
          wr_addr    = addr(i, j);
          if (j == n_last) begin
            j_next = '0;
            i_next = i + CNT_W'(1);
          end else begin
            j_next = j + CNT_W'(1);
          end
        end
      end
      S_DET_RD: begin
        cmd.rd_en  = 1'b1;
        rd_addr_a  = addr(i, i);
        state_next = S_DET_CHK;
      end
      S_DET_CHK: begin
        cmd.mul_det = 1'b1;
        if (stat.rd_a_zero) begin
          cmd.det_zero = 1'b1;
          state_next   = S_FINAL;
        end else begin
          cmd.mul_start = 1'b1;
          state_next    = S_DET_WAIT;
        end
      end
      S_DET_WAIT: begin
        if (stat.mul_done) begin
          cmd.det_take = 1'b1;
          if (i == n_last) begin
            state_next = S_FINAL;
          end else begin
            i_next     = i + CNT_W'(1);
            state_next = S_DET_RD;
          end
        end
      end
      S_FINAL: begin
        if (!stat.out_full) begin
          cmd.out_load = 1'b1;
          i_next       = '0;
          j_next       = '0;
          state_next   = S_LOAD;
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      i     <= '0;
      j     <= '0;
      r     <= '0;
      m     <= '0;
      p     <= '0;
    end else begin
      state <= state_next;
      i     <= i_next;
      j     <= j_next;
      r     <= r_next;
      m     <= m_next;
      p     <= p_next;
    end
  end

endmodule

`default_nettype wire

### hdl/gaussian_elimination_determinant.sv
// loads n*n elements, then eliminates column by column and multiplies the diagonal,
// and each row swap exchanges the two rows one column at a time
// each eliminated row waits on the restoring divider, each entry on the multiplier;
// one matrix at a time, next load starts once the result is registered
// rst is synchronous: size register to 4, load count to zero, result channel empty
// ----------------------------------------------------------------------------
// gaussian_elimination_determinant
// Determinant of a square Q16.16 matrix by row reduction, pivoting on the first nonzero entry.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gaussian_elimination_determinant #(
  parameter int MAX_DIM = 8
) (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               psel,
  input  wire                               penable,
  input  wire                               pwrite,
  input  wire [2:0]                         paddr,
  input  wire [31:0]                        pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  input  wire signed [ged_pkg::ELEM_W-1:0]  element,
  input  wire                               element_valid,
  output logic                              element_ready,
  output logic signed [ged_pkg::DET_W-1:0]  det_value,
  output logic [ged_pkg::SWAP_W-1:0]        row_swaps,
  output logic                              singular,
  output logic                              overflow,
  output logic                              result_valid,
  input  wire                               result_ready
);

  localparam int AW = 2 * $clog2(MAX_DIM);

  logic [ged_pkg::SIZE_W-1:0] matrix_size;
  logic                       cfg_wr;
  ged_pkg::cmd_t              cmd;
  ged_pkg::stat_t             stat;
  logic [AW-1:0]              rd_addr_a;
  logic [AW-1:0]              rd_addr_b;
  logic [AW-1:0]              wr_addr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == ged_pkg::REG_MATRIX_SIZE);
  assign prdata = (paddr[2] == ged_pkg::REG_MATRIX_SIZE) ? {28'd0, matrix_size} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      matrix_size <= 4'd4;
    end else if (cfg_wr) begin
      matrix_size <= pwdata[ged_pkg::SIZE_W-1:0];
    end
  end

  ged_ctrl #(
    .MAX_DIM(MAX_DIM)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .matrix_size  (matrix_size),
    .cfg_wr       (cfg_wr),
    .element_valid(element_valid),
    .element_ready(element_ready),
    .stat         (stat),
    .cmd          (cmd),
    .rd_addr_a    (rd_addr_a),
    .rd_addr_b    (rd_addr_b),
    .wr_addr      (wr_addr)
  );

  ged_datapath #(
    .MAX_DIM(MAX_DIM)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .rd_addr_a   (rd_addr_a),
    .rd_addr_b   (rd_addr_b),
    .wr_addr     (wr_addr),
    .element     (element),
    .det_value   (det_value),
    .row_swaps   (row_swaps),
    .singular    (singular),
    .overflow    (overflow),
    .result_valid(result_valid),
    .result_ready(result_ready)
  );

`ifndef SYNTH
  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    !(cmd.rd_en && cmd.wr_en))
    else $error("matrix ram read and write in the same cycle");

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !result_valid)
    else $error("result register overwritten");

  a_valid_from_load: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(cmd.out_load))
    else $error("result valid without a load");
`endif

endmodule

`default_nettype wire
